// ===== rtl/core/tdpc_pkg.sv =====
`timescale 1ns / 1ps
// tdpc_pkg: shared types, state encoding and constants of the trial-division prime counter
// depends on nothing; imported by the top level and the checker

package tdpc_pkg;

    // fixed field widths of the channels
    localparam int FIELD_VALUE_WIDTH = 32;
    localparam int FIELD_COUNT_WIDTH = 32;

    // first odd trial divisor and its square
    localparam int FIRST_DIVISOR        = 3;
    localparam int FIRST_DIVISOR_SQUARE = 9;

    typedef struct packed {
        logic [FIELD_VALUE_WIDTH-1:0] value;
        logic                         last;
    } item_t;

    typedef struct packed {
        logic                         prime_flag;
        logic [FIELD_COUNT_WIDTH-1:0] prime_count;
        logic [FIELD_COUNT_WIDTH-1:0] item_count;
        logic                         batch_end;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/core/trial_division_prime_counter_top.sv =====
`timescale 1ns / 1ps
// trial_division_prime_counter_top: primality test by trial division with batch counters
// depends on tdpc_pkg (item_t, result_t, state_t, constants)
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+------------------------------------
//  item     | in        | item_valid / item_stall     | value (signed), last
//  result   | out       | result_valid / result_stall | prime_flag, prime_count, item_count,
//           |           |                             | batch_end
//
// one item at a time: item_stall is high from acceptance until the result is
// handed to the output register, which then frees the input while the result waits
// negative, 0, 1, 2 and even values go straight to the finish state; an odd value v
// passes through a check and a division per odd divisor d with d*d <= v, up to the first
// that divides it; the bit-serial remainder unit shifts in one bit of v per cycle
// worst case at 32 bits is about 23170 divisors
// reset (rst_n, asynchronous, active low) clears state, counts and result valid
// a stalled result holds in the output register; the next transaction may still be
// tested meanwhile but waits in the finish state until the register is free

module trial_division_prime_counter_top #(
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  tdpc_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output tdpc_pkg::result_t result
);

    import tdpc_pkg::*;

    // widths derived from the parameters
    localparam int VXW  = (VALUE_WIDTH > FIELD_VALUE_WIDTH) ? VALUE_WIDTH : FIELD_VALUE_WIDTH;
    localparam int CXW  = (COUNT_WIDTH > FIELD_COUNT_WIDTH) ? COUNT_WIDTH : FIELD_COUNT_WIDTH;
    localparam int SQW  = VALUE_WIDTH + 2;          // divisor square, can pass v by a step
    localparam int CNTW = $clog2(VALUE_WIDTH);      // bit index within one division

    localparam logic [CNTW-1:0]        LAST_BIT  = CNTW'(VALUE_WIDTH - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // control and datapath registers
    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;    // number under test
    logic [VALUE_WIDTH-1:0] shift_reg, shift_next;    // dividend bits, msb first
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;        // partial remainder
    logic [VALUE_WIDTH-1:0] div_reg, div_next;        // current odd divisor
    logic [SQW-1:0]         sq_reg, sq_next;          // square of the divisor
    logic [CNTW-1:0]        bit_cnt_reg, bit_cnt_next;
    logic                   prime_reg, prime_next;
    logic                   last_reg, last_next;
    logic [COUNT_WIDTH-1:0] primes_reg, primes_next;
    logic [COUNT_WIDTH-1:0] items_reg, items_next;
    result_t                result_reg, result_next;
    logic                   result_valid_reg, result_valid_next;

    // incoming value cut or zero-extended to the working width
    logic [VXW-1:0]         value_ext;
    logic [VALUE_WIDTH-1:0] value_in;

    // one step of the restoring remainder
    logic [VALUE_WIDTH:0]   rem_shifted;
    logic                   rem_ge;
    logic [VALUE_WIDTH-1:0] rem_step;

    // counts after this transaction, before a batch clear
    logic [COUNT_WIDTH-1:0] primes_inc, items_inc;
    logic [CXW-1:0]         primes_ext, items_ext;

    logic accept_item;
    logic result_free;
    logic sq_over;

    assign value_ext = VXW'(item.value);
    assign value_in  = value_ext[VALUE_WIDTH-1:0];

    assign accept_item = item_valid && !item_stall;
    assign result_free = !result_valid_reg || !result_stall;

    assign rem_shifted = {rem_reg, shift_reg[VALUE_WIDTH-1]};
    assign rem_ge      = rem_shifted >= {1'b0, div_reg};
    assign rem_step    = rem_ge ? VALUE_WIDTH'(rem_shifted - {1'b0, div_reg})
                                : rem_shifted[VALUE_WIDTH-1:0];

    // search ends once the divisor square passes the value
    assign sq_over = sq_reg > {2'b00, value_reg};

    // saturating counts
    assign items_inc  = (items_reg == COUNT_MAX) ? items_reg : items_reg + 1'b1;
    assign primes_inc = (prime_reg && (primes_reg != COUNT_MAX)) ? primes_reg + 1'b1
                                                                 : primes_reg;
    assign primes_ext = CXW'(primes_inc);
    assign items_ext  = CXW'(items_inc);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_item)
                begin
                    // sign, below two, two and even values are settled at once
                    if (value_in[VALUE_WIDTH-1] || (value_in[VALUE_WIDTH-1:1] == '0)
                        || !value_in[0])
                        state_next = ST_FINISH;
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = sq_over ? ST_FINISH : ST_DIV;
            end
            ST_DIV:
            begin
                if (bit_cnt_reg == LAST_BIT)
                    state_next = (rem_step == '0) ? ST_FINISH : ST_CHECK;
            end
            ST_FINISH:
            begin
                if (result_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        value_next        = value_reg;
        shift_next        = shift_reg;
        rem_next          = rem_reg;
        div_next          = div_reg;
        sq_next           = sq_reg;
        bit_cnt_next      = bit_cnt_reg;
        prime_next        = prime_reg;
        last_next         = last_reg;
        primes_next       = primes_reg;
        items_next        = items_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        item_stall        = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (accept_item)
                begin
                    value_next = value_in;
                    last_next  = item.last;
                    div_next   = VALUE_WIDTH'(FIRST_DIVISOR);
                    sq_next    = SQW'(FIRST_DIVISOR_SQUARE);
                    // only two is an even prime; odd values above one stay open
                    prime_next = !value_in[VALUE_WIDTH-1]
                                 && (value_in[VALUE_WIDTH-1:1] != '0)
                                 && (value_in[0] || (value_in[VALUE_WIDTH-1:2] == '0));
                end
            end
            ST_CHECK:
            begin
                shift_next   = value_reg;
                rem_next     = '0;
                bit_cnt_next = '0;
            end
            ST_DIV:
            begin
                shift_next   = {shift_reg[VALUE_WIDTH-2:0], 1'b0};
                rem_next     = rem_step;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == LAST_BIT)
                begin
                    if (rem_step == '0)
                        prime_next = 1'b0;
                    // (d+2)^2 = d^2 + 4d + 4
                    div_next = div_reg + VALUE_WIDTH'(2);
                    sq_next  = sq_reg + {div_reg, 2'b00} + SQW'(4);
                end
            end
            ST_FINISH:
            begin
                if (result_free)
                begin
                    result_next.prime_flag  = prime_reg;
                    result_next.prime_count = primes_ext[FIELD_COUNT_WIDTH-1:0];
                    result_next.item_count  = items_ext[FIELD_COUNT_WIDTH-1:0];
                    result_next.batch_end   = last_reg;
                    result_valid_next       = 1'b1;
                    primes_next = last_reg ? '0 : primes_inc;
                    items_next  = last_reg ? '0 : items_inc;
                end
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            primes_reg       <= '0;
            items_reg        <= '0;
            result_valid_reg <= 1'b0;
            bit_cnt_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            primes_reg       <= primes_next;
            items_reg        <= items_next;
            result_valid_reg <= result_valid_next;
            bit_cnt_reg      <= bit_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        shift_reg  <= shift_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        sq_reg     <= sq_next;
        prime_reg  <= prime_next;
        last_reg   <= last_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/core/tdpc_checker.sv =====
`timescale 1ns / 1ps
// tdpc_checker: port-level assertions for the trial-division prime counter
// depends on tdpc_pkg and trial_division_prime_counter_top (bound below)

module tdpc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input tdpc_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_stall,
    input tdpc_pkg::result_t result
);

    import tdpc_pkg::*;

    // a stalled result holds
    property p_result_hold;
        @(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result);
    endproperty
    a_result_hold: assert property (p_result_hold)
        else $error("stalled result changed");

    // one transaction at a time
    property p_one_at_a_time;
        @(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall;
    endproperty
    a_one_at_a_time: assert property (p_one_at_a_time)
        else $error("input not stalled after a transaction");

    // every result counts at least its own item
    property p_item_count_nonzero;
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> result.item_count != '0;
    endproperty
    a_item_count_nonzero: assert property (p_item_count_nonzero)
        else $error("item count zero on a result");

    // primes never outnumber items
    property p_primes_le_items;
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> result.prime_count <= result.item_count;
    endproperty
    a_primes_le_items: assert property (p_primes_le_items)
        else $error("prime count above item count");

    // a prime result is counted
    property p_prime_counted;
        @(posedge clk) disable iff (!rst_n)
        result_valid && result.prime_flag |-> result.prime_count != '0;
    endproperty
    a_prime_counted: assert property (p_prime_counted)
        else $error("prime flagged but prime count zero");

endmodule

bind trial_division_prime_counter_top tdpc_checker u_tdpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
